// ===== hdl/ecdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ecdf_pkg
// Types and constants shared by the escaped frame deframer modules.
// ----------------------------------------------------------------------------
package ecdf_pkg;

  localparam int unsigned MinFrameBytes = 7;
  localparam int unsigned MaxFrameBytes = 23;
  localparam int unsigned HeaderBytes   = 3;
  localparam int unsigned MaxDataBytes  = 8;

  localparam logic [7:0] EscDelimCode = 8'h64;
  localparam logic [4:0] CountMax     = 5'd31;

  localparam logic CfgDelimiter = 1'b0;
  localparam logic CfgEscape    = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_BAD_ESCAPE = 3'd3,
    ST_LEN_MISM   = 3'd4,
    ST_LEN_OVER   = 3'd5
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] id;
    logic [3:0]  len;
    logic [63:0] payload;
  } result_t;

endpackage

// ===== hdl/ecdf_decoder.sv =====
// ----------------------------------------------------------------------------
// ecdf_decoder
// Removes the escape coding, collects header and payload bytes, and forms
// the frame result when a delimiter transaction arrives.
// ----------------------------------------------------------------------------
module ecdf_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       delimiter_i,
  input  logic [7:0]       escape_i,
  output logic             res_valid_o,
  output ecdf_pkg::result_t res_o
);
  import ecdf_pkg::*;

  logic [4:0] raw_cnt_q, raw_cnt_d;
  logic [4:0] dec_cnt_q, dec_cnt_d;
  logic       esc_pend_q, esc_pend_d;
  logic       esc_err_q, esc_err_d;
  logic [7:0] id_lo_q, id_hi_q, len_q;
  logic [7:0] data_q [MaxDataBytes];

  logic       is_delim;
  logic       store;
  logic [7:0] store_byte;
  logic [4:0] data_off;
  logic [5:0] total;
  logic [8:0] len_plus_hdr;
  status_e    status;
  logic [63:0] pay;

  assign is_delim = (rx_byte_i == delimiter_i);
  assign data_off = dec_cnt_q - 5'(HeaderBytes);

  always_comb begin
    raw_cnt_d  = raw_cnt_q;
    dec_cnt_d  = dec_cnt_q;
    esc_pend_d = esc_pend_q;
    esc_err_d  = esc_err_q;
    store      = 1'b0;
    store_byte = rx_byte_i;
    if (accept_i) begin
      if (is_delim) begin
        raw_cnt_d  = '0;
        dec_cnt_d  = '0;
        esc_pend_d = 1'b0;
        esc_err_d  = 1'b0;
      end else begin
        if (raw_cnt_q != CountMax) raw_cnt_d = raw_cnt_q + 5'd1;
        if (esc_pend_q) begin
          esc_pend_d = 1'b0;
          if (rx_byte_i == escape_i) begin
            store      = 1'b1;
            store_byte = escape_i;
          end else if (rx_byte_i == EscDelimCode) begin
            store      = 1'b1;
            store_byte = delimiter_i;
          end else begin
            esc_err_d = 1'b1;
          end
        end else if (rx_byte_i == escape_i) begin
          esc_pend_d = 1'b1;
        end else begin
          store = 1'b1;
        end
        if (store && dec_cnt_q != CountMax) dec_cnt_d = dec_cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_cnt_q  <= '0;
      dec_cnt_q  <= '0;
      esc_pend_q <= 1'b0;
      esc_err_q  <= 1'b0;
    end else begin
      raw_cnt_q  <= raw_cnt_d;
      dec_cnt_q  <= dec_cnt_d;
      esc_pend_q <= esc_pend_d;
      esc_err_q  <= esc_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      if (dec_cnt_q == 5'd0) begin
        id_lo_q <= store_byte;
      end else if (dec_cnt_q == 5'd1) begin
        id_hi_q <= store_byte;
      end else if (dec_cnt_q == 5'd2) begin
        len_q <= store_byte;
      end else if (dec_cnt_q < 5'(HeaderBytes + MaxDataBytes)) begin
        data_q[data_off[2:0]] <= store_byte;
      end
    end
  end

  assign total        = {1'b0, raw_cnt_q} + 6'd1;
  assign len_plus_hdr = {1'b0, len_q} + 9'(HeaderBytes);

  always_comb begin
    if (total < 6'(MinFrameBytes)) begin
      status = ST_TOO_SHORT;
    end else if (total > 6'(MaxFrameBytes)) begin
      status = ST_TOO_LONG;
    end else if (esc_err_q || esc_pend_q) begin
      status = ST_BAD_ESCAPE;
    end else if (len_plus_hdr != {4'd0, dec_cnt_q}) begin
      status = ST_LEN_MISM;
    end else if (len_q > 8'(MaxDataBytes)) begin
      status = ST_LEN_OVER;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxDataBytes; i++) begin
      pay[8*i +: 8] = (8'(i) < len_q) ? data_q[i] : 8'd0;
    end
  end

  always_comb begin
    res_o.status  = status;
    res_o.id      = '0;
    res_o.len     = '0;
    res_o.payload = '0;
    if (status == ST_OK) begin
      res_o.id      = {id_hi_q, id_lo_q};
      res_o.len     = len_q[3:0];
      res_o.payload = pay;
    end
  end

  assign res_valid_o = accept_i && is_delim;

endmodule

// ===== hdl/ecdf_out_stage.sv =====
// ----------------------------------------------------------------------------
// ecdf_out_stage
// Result register with a skid entry, so that input transactions continue
// while a finished result waits at the output.
// ----------------------------------------------------------------------------
module ecdf_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  ecdf_pkg::result_t res_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ecdf_pkg::result_t out_o
);
  import ecdf_pkg::*;

  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_take;

  assign out_take = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (res_valid_i) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hdl/escaped_can_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// escaped_can_frame_deframer_top
// Deframer for an escaped telemetry byte stream: one raw byte per cycle while
// the skid entry is free, a throughput set by the per-byte decode update.
// Each frame result is registered, in the skid entry while an output waits.
// A two-entry result stage keeps input open while one result waits.
// Reset clears counters, flags and valid bits; byte stores are not reset.
// ----------------------------------------------------------------------------
module escaped_can_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  frame_status_o,
  output logic [15:0] frame_id_o,
  output logic [3:0]  data_length_o,
  output logic [63:0] payload_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import ecdf_pkg::*;

  logic [7:0] delim_q, esc_q;
  logic       accept;
  logic       res_valid;
  result_t    res, out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= 8'd10;
      esc_q   <= 8'd92;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDelimiter: delim_q <= cfg_data_i;
        CfgEscape:    esc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  ecdf_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .delimiter_i (delim_q),
    .escape_i    (esc_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ecdf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign frame_status_o = out.status;
  assign frame_id_o     = out.id;
  assign data_length_o  = out.len;
  assign payload_o      = out.payload;

  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("result stage full without a pending output");

  a_delim_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_byte_i == delim_q) |=> out_valid_o)
    else $error("delimiter transaction produced no result");

  a_fail_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o != ST_OK) |->
      (frame_id_o == 16'd0 && data_length_o == 4'd0 && payload_o == 64'd0))
    else $error("failed frame carries non-zero fields");

  a_ok_length_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_OK) |-> (data_length_o <= 4'd8))
    else $error("accepted frame reports a length above eight");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the escaped frame deframer. Byte transactions are driven
// against a cycle-free prediction of the decoder. Each frame result from the
// block is checked field by field against the oldest predicted result.
// Directed frames come first, then random frames under several delimiter and
// escape settings and under several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  import ecdf_pkg::*;

  localparam int unsigned WatchdogLimit    = 4000;
  localparam logic [7:0]  DefaultDelimiter = 8'd10;
  localparam logic [7:0]  DefaultEscape    = 8'd92;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int unsigned {
    FK_GOOD,
    FK_LEN_MISM,
    FK_LEN_OVER,
    FK_TOO_LONG,
    FK_BAD_PAIR,
    FK_ESC_AT_END,
    FK_NOISE
  } frame_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  frame_status_o;
  logic [15:0] frame_id_o;
  logic [3:0]  data_length_o;
  logic [63:0] payload_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_data_i;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned n_errors    = 0;
  int unsigned quiet_count = 0;

  // Decoder state as the block should hold it.
  logic [7:0] delim_reg;
  logic [7:0] esc_reg;
  logic [4:0] raw_cnt;
  logic [4:0] dec_cnt;
  logic       esc_open;
  logic       esc_bad;
  logic [7:0] id_lo;
  logic [7:0] id_hi;
  logic [7:0] len_byte;
  logic [7:0] data_bytes [MaxDataBytes];
  result_t    pending_frames[$];

  escaped_can_frame_deframer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .frame_id_o     (frame_id_o),
    .data_length_o  (data_length_o),
    .payload_o      (payload_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic store_plain(input logic [7:0] b);
    if (dec_cnt == 5'd0) begin
      id_lo = b;
    end else if (dec_cnt == 5'd1) begin
      id_hi = b;
    end else if (dec_cnt == 5'd2) begin
      len_byte = b;
    end else if (dec_cnt < HeaderBytes + MaxDataBytes) begin
      data_bytes[dec_cnt - HeaderBytes] = b;
    end
    if (dec_cnt != CountMax) begin
      dec_cnt = dec_cnt + 5'd1;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    result_t     r;
    int unsigned total;
    if (b == delim_reg) begin
      r = '0;
      total = int'(raw_cnt) + 1;
      if (total < MinFrameBytes) begin
        r.status = ST_TOO_SHORT;
      end else if (total > MaxFrameBytes) begin
        r.status = ST_TOO_LONG;
      end else if (esc_bad || esc_open) begin
        r.status = ST_BAD_ESCAPE;
      end else if (int'(len_byte) + HeaderBytes != int'(dec_cnt)) begin
        r.status = ST_LEN_MISM;
      end else if (len_byte > MaxDataBytes) begin
        r.status = ST_LEN_OVER;
      end else begin
        r.status = ST_OK;
        r.id     = {id_hi, id_lo};
        r.len    = len_byte[3:0];
        for (int i = 0; i < int'(len_byte); i++) begin
          r.payload[8*i +: 8] = data_bytes[i];
        end
      end
      pending_frames.push_back(r);
      raw_cnt  = '0;
      dec_cnt  = '0;
      esc_open = 1'b0;
      esc_bad  = 1'b0;
    end else begin
      if (raw_cnt != CountMax) begin
        raw_cnt = raw_cnt + 5'd1;
      end
      if (esc_open) begin
        esc_open = 1'b0;
        if (b == esc_reg) begin
          store_plain(esc_reg);
        end else if (b == EscDelimCode) begin
          store_plain(delim_reg);
        end else begin
          esc_bad = 1'b1;
        end
      end else if (b == esc_reg) begin
        esc_open = 1'b1;
      end else begin
        store_plain(b);
      end
    end
  endtask

  // Results are sampled at the falling edge, where the handshake signals
  // already hold the values seen by the next rising edge.
  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result transaction: frame_status %0d", frame_status_o);
        n_errors++;
      end else begin
        want = pending_frames.pop_front();
        if (frame_status_o !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, frame_status_o);
          n_errors++;
        end
        if (frame_id_o !== want.id) begin
          $error("frame_id: expected %h, got %h", want.id, frame_id_o);
          n_errors++;
        end
        if (data_length_o !== want.len) begin
          $error("data_length: expected %0d, got %0d", want.len, data_length_o);
          n_errors++;
        end
        if (payload_o !== want.payload) begin
          $error("payload: expected %h, got %h", want.payload, payload_o);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WatchdogLimit) begin
      $display("[escaped_can_frame_deframer_top] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_raw(input byte_q_t bytes);
    foreach (bytes[i]) begin
      send_byte(bytes[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CfgDelimiter) begin
      delim_reg = value;
    end else begin
      esc_reg = value;
    end
    cfg_we_i <= 1'b0;
  endtask

  // A delimiter value cannot be carried in the payload when no escape pair
  // decodes to it; such bytes are moved to a neighbouring value.
  function automatic logic [7:0] fix_byte(input logic [7:0] b);
    if (b == delim_reg && (esc_reg == delim_reg || esc_reg == EscDelimCode ||
                           delim_reg == EscDelimCode)) begin
      return b ^ 8'h01;
    end
    return b;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(15);
    if (r < 3) return fix_byte(esc_reg);
    if (r < 5) return fix_byte(delim_reg);
    if (r == 5) return fix_byte(EscDelimCode);
    return fix_byte(8'($urandom_range(255)));
  endfunction

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return FK_GOOD;
    if (r < 65) return FK_LEN_MISM;
    if (r < 73) return FK_LEN_OVER;
    if (r < 80) return FK_TOO_LONG;
    if (r < 88) return FK_BAD_PAIR;
    if (r < 93) return FK_ESC_AT_END;
    return FK_NOISE;
  endfunction

  task automatic send_frame(input frame_kind_e kind);
    byte_q_t     plain;
    byte_q_t     raw;
    int unsigned len_val;
    int unsigned n_data;
    int          bad_at;
    logic [7:0]  ill;
    logic        can_escape;
    can_escape = (esc_reg != delim_reg);
    len_val    = $urandom_range(MaxDataBytes);
    n_data     = len_val;
    case (kind)
      FK_LEN_MISM: begin
        if ($urandom_range(3) == 0) begin
          len_val = $urandom_range(255);
        end
        do begin
          n_data = $urandom_range(11);
        end while (n_data == len_val);
      end
      FK_LEN_OVER: begin
        len_val = $urandom_range(15, 9);
        n_data  = len_val;
      end
      FK_TOO_LONG: begin
        n_data = $urandom_range(28, 20);
      end
      default: begin
      end
    endcase
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(40, 1)) raw.push_back(8'($urandom_range(255)));
    end else begin
      plain.push_back(pick_byte());
      plain.push_back(pick_byte());
      plain.push_back(fix_byte(8'(len_val)));
      repeat (n_data) plain.push_back(pick_byte());
      bad_at = $urandom_range(plain.size() - 1);
      foreach (plain[i]) begin
        if (kind == FK_BAD_PAIR && can_escape && i == bad_at) begin
          do begin
            ill = 8'($urandom_range(255));
          end while (ill == esc_reg || ill == EscDelimCode || ill == delim_reg);
          raw.push_back(esc_reg);
          raw.push_back(ill);
        end
        if (plain[i] == esc_reg) begin
          raw.push_back(esc_reg);
          raw.push_back(esc_reg);
        end else if (plain[i] == delim_reg) begin
          raw.push_back(esc_reg);
          raw.push_back(EscDelimCode);
        end else begin
          raw.push_back(plain[i]);
        end
      end
      if (kind == FK_ESC_AT_END && can_escape) begin
        raw.push_back(esc_reg);
      end
    end
    raw.push_back(delim_reg);
    send_raw(raw);
  endtask

  // Shortest legal frame: both escape pairs, one data byte, reset settings.
  task automatic test_min_frame();
    byte_q_t q;
    q = '{esc_reg, esc_reg, esc_reg, EscDelimCode, 8'h01, 8'hFF, delim_reg};
    send_raw(q);
  endtask

  task automatic test_too_short();
    byte_q_t q;
    q = '{delim_reg};
    send_raw(q);
  endtask

  task automatic test_bad_escape();
    byte_q_t q;
    q = '{8'h00, 8'hFF, 8'h01, esc_reg, 8'h41, 8'h80, delim_reg};
    send_raw(q);
    q = '{8'h12, 8'h34, 8'h00, 8'h55, 8'hAA, esc_reg, delim_reg};
    send_raw(q);
  endtask

  task automatic test_random_phase(input logic [7:0] delim, input logic [7:0] esc,
                                   input int unsigned idle, input int unsigned stall,
                                   input int unsigned n_bytes);
    int unsigned start;
    write_reg(CfgDelimiter, delim);
    write_reg(CfgEscape, esc);
    idle_pct  = idle;
    stall_pct = stall;
    start     = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      send_frame(pick_kind());
    end
  endtask

  // The sender holds off after every frame until its result has arrived.
  task automatic test_pressure();
    write_reg(CfgDelimiter, DefaultDelimiter);
    write_reg(CfgEscape, DefaultEscape);
    idle_pct  = 12;
    stall_pct = 12;
    repeat (6) begin
      send_frame(FK_GOOD);
      wait_drained();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    out_ready_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgDelimiter;
    cfg_data_i  <= 8'h00;
    delim_reg   = DefaultDelimiter;
    esc_reg     = DefaultEscape;
    raw_cnt     = '0;
    dec_cnt     = '0;
    esc_open    = 1'b0;
    esc_bad     = 1'b0;
    id_lo       = '0;
    id_hi       = '0;
    len_byte    = '0;
    foreach (data_bytes[i]) data_bytes[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_min_frame();
    test_too_short();
    test_bad_escape();

    test_random_phase(DefaultDelimiter, DefaultEscape, 0, 0, 75);
    test_random_phase(8'h00, 8'hFF, 88, 0, 75);
    test_random_phase(8'hFF, 8'h00, 0, 88, 75);
    test_random_phase(EscDelimCode, DefaultEscape, 12, 12, 75);
    test_random_phase(DefaultDelimiter, EscDelimCode, 0, 0, 75);
    test_random_phase(8'h7E, 8'h7E, 88, 0, 75);
    test_random_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 0, 88, 75);
    test_random_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 12, 12, 75);
    test_pressure();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && pending_frames.size() == 0) begin
      $display("[escaped_can_frame_deframer_top] OK");
    end else begin
      $display("[escaped_can_frame_deframer_top] ERROR");
    end
    $finish;
  end

endmodule
